// File: design/stlc_pkg.sv
package stlc_pkg;

  localparam int NODES_DEFAULT = 256;
  localparam int LABELS        = 256;
  localparam int LABEL_W       = 8;
  localparam int COUNT_W       = 9;
  localparam int EDGE_W        = 8;
  localparam int STEP_W        = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [EDGE_W-1:0]  EDGE_MAX  = '1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_RD_A,
    OP_RD_B,
    OP_CAP_LB,
    OP_RD_CA,
    OP_RD_CB,
    OP_PICK,
    OP_SCAN,
    OP_SCAN_TAIL,
    OP_WR_SUM,
    OP_WR_ZERO,
    OP_OPEN_A,
    OP_OPEN_B,
    OP_JOIN,
    OP_CLR_INIT,
    OP_CLR,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    H_NONE,
    H_NO_BEAT,
    H_SCAN_MORE,
    H_CLR_MORE,
    H_OUT_BUSY
  } hold_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_RESTART,
    C_BAD,
    C_BOTH_ZERO,
    C_SAME,
    C_ONE_ZERO,
    C_NO_LABEL,
    C_BOOT
  } cond_t;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic beat;
    logic restart;
    logic bad;
    logic both_zero;
    logic same;
    logic one_zero;
    logic no_label;
    logic boot;
    logic scan_more;
    logic clr_more;
    logic out_busy;
  } status_t;

  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_DISPATCH = 5'd1;
  localparam step_t S_RD_A     = 5'd2;
  localparam step_t S_RD_B     = 5'd3;
  localparam step_t S_CAP_LB   = 5'd4;
  localparam step_t S_RD_CA    = 5'd5;
  localparam step_t S_RD_CB    = 5'd6;
  localparam step_t S_PICK     = 5'd7;
  localparam step_t S_SCAN     = 5'd8;
  localparam step_t S_TAIL     = 5'd9;
  localparam step_t S_WR_SUM   = 5'd10;
  localparam step_t S_WR_ZERO  = 5'd11;
  localparam step_t S_OPEN     = 5'd12;
  localparam step_t S_OPEN_B   = 5'd13;
  localparam step_t S_JOIN     = 5'd14;
  localparam step_t S_CLR_INIT = 5'd15;
  localparam step_t S_CLR      = 5'd16;
  localparam step_t S_EMIT     = 5'd17;

  // Control store: stay while hold is true, else jump on cond, else fall through.
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    begin
      case (step)
        S_IDLE:     w = '{OP_ACCEPT,    H_NO_BEAT,   C_NEVER,     S_IDLE};
        S_DISPATCH: w = '{OP_NOP,       H_NONE,      C_RESTART,   S_CLR_INIT};
        S_RD_A:     w = '{OP_RD_A,      H_NONE,      C_BAD,       S_EMIT};
        S_RD_B:     w = '{OP_RD_B,      H_NONE,      C_NEVER,     S_IDLE};
        S_CAP_LB:   w = '{OP_CAP_LB,    H_NONE,      C_NEVER,     S_IDLE};
        S_RD_CA:    w = '{OP_RD_CA,     H_NONE,      C_BOTH_ZERO, S_OPEN};
        S_RD_CB:    w = '{OP_RD_CB,     H_NONE,      C_SAME,      S_EMIT};
        S_PICK:     w = '{OP_PICK,      H_NONE,      C_ONE_ZERO,  S_JOIN};
        S_SCAN:     w = '{OP_SCAN,      H_SCAN_MORE, C_NEVER,     S_IDLE};
        S_TAIL:     w = '{OP_SCAN_TAIL, H_NONE,      C_NEVER,     S_IDLE};
        S_WR_SUM:   w = '{OP_WR_SUM,    H_NONE,      C_NEVER,     S_IDLE};
        S_WR_ZERO:  w = '{OP_WR_ZERO,   H_NONE,      C_ALWAYS,    S_EMIT};
        S_OPEN:     w = '{OP_OPEN_A,    H_NONE,      C_NO_LABEL,  S_EMIT};
        S_OPEN_B:   w = '{OP_OPEN_B,    H_NONE,      C_ALWAYS,    S_EMIT};
        S_JOIN:     w = '{OP_JOIN,      H_NONE,      C_ALWAYS,    S_EMIT};
        S_CLR_INIT: w = '{OP_CLR_INIT,  H_NONE,      C_NEVER,     S_IDLE};
        S_CLR:      w = '{OP_CLR,       H_CLR_MORE,  C_BOOT,      S_IDLE};
        S_EMIT:     w = '{OP_EMIT,      H_OUT_BUSY,  C_ALWAYS,    S_IDLE};
        default:    w = '{OP_NOP,       H_NONE,      C_ALWAYS,    S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// File: design/spanning_tree_link_classifier.sv
// channel | handshake           | payload
// in      | in_valid / in_ready | func, node_a, node_b
// out     | out_valid/out_ready | link_kept, groups_joined, group_opened, tree_edge_total
//
// One item at a time. An ignored link goes to the output step after its range
// check, a redundant one after its label lookups; opening a group or joining a
// node writes both RAMs, and a merge adds a sweep of the node label RAM.
// A restart clears both RAMs one entry a cycle, over max(NODES, 256) entries.
// After reset the same clearing pass runs with in_ready low. A stalled output holds
// its beat; the next item is taken meanwhile and waits in its last step until the
// output register frees.
module spanning_tree_link_classifier #(
  parameter int NODES = stlc_pkg::NODES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [7:0]                  node_a,
  input  logic [7:0]                  node_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        link_kept,
  output logic                        groups_joined,
  output logic                        group_opened,
  output logic [stlc_pkg::EDGE_W-1:0] tree_edge_total
);
  import stlc_pkg::*;

  op_t     op;
  status_t status;

  stlc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .op    (op)
  );

  stlc_datapath #(
    .NODES(NODES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .status         (status),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .node_a         (node_a),
    .node_b         (node_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .link_kept      (link_kept),
    .groups_joined  (groups_joined),
    .group_opened   (group_opened),
    .tree_edge_total(tree_edge_total)
  );

endmodule

// File: design/stlc_ram.sv
module stlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/stlc_sequencer.sv
module stlc_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  stlc_pkg::status_t status,
  output stlc_pkg::op_t     op
);
  import stlc_pkg::*;

  step_t      pc;
  step_t      pc_next;
  ctrl_word_t ctrl;
  logic       hold_hit;
  logic       cond_hit;

  assign ctrl = ucode(pc);
  assign op   = ctrl.op;

  always_comb begin
    case (ctrl.hold)
      H_NONE:      hold_hit = 1'b0;
      H_NO_BEAT:   hold_hit = !status.beat;
      H_SCAN_MORE: hold_hit = status.scan_more;
      H_CLR_MORE:  hold_hit = status.clr_more;
      H_OUT_BUSY:  hold_hit = status.out_busy;
      default:     hold_hit = 1'b0;
    endcase

    case (ctrl.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_RESTART:   cond_hit = status.restart;
      C_BAD:       cond_hit = status.bad;
      C_BOTH_ZERO: cond_hit = status.both_zero;
      C_SAME:      cond_hit = status.same;
      C_ONE_ZERO:  cond_hit = status.one_zero;
      C_NO_LABEL:  cond_hit = status.no_label;
      C_BOOT:      cond_hit = status.boot;
      default:     cond_hit = 1'b0;
    endcase

    if (hold_hit) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  // Reset enters the clearing pass; the boot flag skips its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLR_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/stlc_datapath.sv
module stlc_datapath #(
  parameter int NODES = stlc_pkg::NODES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stlc_pkg::op_t                  op,
  output stlc_pkg::status_t              status,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [7:0]                     node_a,
  input  logic [7:0]                     node_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           link_kept,
  output logic                           groups_joined,
  output logic                           group_opened,
  output logic [stlc_pkg::EDGE_W-1:0]    tree_edge_total
);
  import stlc_pkg::*;

  localparam int NAW   = $clog2(NODES);
  localparam int SWEEP = (NODES > LABELS) ? NODES : LABELS;
  localparam int IW    = $clog2(SWEEP);
  localparam int GAW   = $clog2(LABELS);
  localparam logic [IW-1:0] SCAN_LAST = IW'(NODES - 1);
  localparam logic [IW-1:0] CLR_LAST  = IW'(SWEEP - 1);

  // item registers
  logic               func_r;
  logic [7:0]         a_r;
  logic [7:0]         b_r;
  logic [LABEL_W-1:0] la;
  logic [LABEL_W-1:0] lb;
  logic [COUNT_W-1:0] ca;
  logic [COUNT_W-1:0] cb;
  logic [LABEL_W-1:0] from_lbl;
  logic [LABEL_W-1:0] to_lbl;
  logic [IW-1:0]      idx;
  logic [NAW-1:0]     idx_d;
  logic               scan_vld;
  logic               kept;
  logic               joined;
  logic               opened;

  // persistent state
  logic               boot;
  logic [LABEL_W-1:0] next_label;
  logic [EDGE_W-1:0]  edge_count;
  logic [EDGE_W-1:0]  edge_next;

  // memory ports
  logic               node_we;
  logic [NAW-1:0]     node_waddr;
  logic [LABEL_W-1:0] node_wdata;
  logic [NAW-1:0]     node_raddr;
  logic [LABEL_W-1:0] node_rdata;
  logic               grp_we;
  logic [GAW-1:0]     grp_waddr;
  logic [COUNT_W-1:0] grp_wdata;
  logic [GAW-1:0]     grp_raddr;
  logic [COUNT_W-1:0] grp_rdata;

  logic [NAW-1:0]     a_idx;
  logic [NAW-1:0]     b_idx;
  logic [COUNT_W:0]   sum_wide;
  logic [COUNT_W-1:0] sum_sat;
  logic [LABEL_W-1:0] join_lbl;
  logic [NAW-1:0]     join_node;
  logic [COUNT_W-1:0] join_cnt;
  logic [COUNT_W-1:0] join_inc;
  logic               scan_hit;
  logic               beat;
  logic               out_free;

  assign in_ready = (op == OP_ACCEPT);
  assign beat     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign a_idx     = NAW'(a_r);
  assign b_idx     = NAW'(b_r);
  assign sum_wide  = {1'b0, ca} + {1'b0, cb};
  assign sum_sat   = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
  assign join_lbl  = (la != '0) ? la : lb;
  assign join_node = (la != '0) ? b_idx : a_idx;
  assign join_cnt  = (la != '0) ? ca : cb;
  assign join_inc  = (join_cnt == COUNT_MAX) ? join_cnt : join_cnt + COUNT_W'(1);
  assign edge_next = (edge_count == EDGE_MAX) ? edge_count : edge_count + EDGE_W'(1);
  assign scan_hit  = scan_vld && (node_rdata == from_lbl);

  always_comb begin
    status.beat      = beat;
    status.restart   = func_r;
    status.bad       = (32'(a_r) >= NODES) || (32'(b_r) >= NODES);
    status.both_zero = (la == '0) && (lb == '0);
    status.same      = (la == lb);
    status.one_zero  = (la == '0) || (lb == '0);
    status.no_label  = (next_label == '0);
    status.boot      = boot;
    status.scan_more = (idx != SCAN_LAST);
    status.clr_more  = (idx != CLR_LAST);
    status.out_busy  = !out_free;
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    grp_we     = 1'b0;
    grp_waddr  = '0;
    grp_wdata  = '0;
    grp_raddr  = '0;
    case (op)
      OP_RD_A: node_raddr = a_idx;
      OP_RD_B: node_raddr = b_idx;
      OP_RD_CA: grp_raddr = GAW'(la);
      OP_RD_CB: grp_raddr = GAW'(lb);
      OP_SCAN: begin
        // read one entry ahead, rewrite the one read last cycle
        node_raddr = idx[NAW-1:0];
        node_we    = scan_hit;
        node_waddr = idx_d;
        node_wdata = to_lbl;
      end
      OP_SCAN_TAIL: begin
        node_we    = scan_hit;
        node_waddr = idx_d;
        node_wdata = to_lbl;
      end
      OP_WR_SUM: begin
        grp_we    = 1'b1;
        grp_waddr = GAW'(to_lbl);
        grp_wdata = sum_sat;
      end
      OP_WR_ZERO: begin
        grp_we    = 1'b1;
        grp_waddr = GAW'(from_lbl);
      end
      OP_OPEN_A: begin
        node_we    = 1'b1;
        node_waddr = a_idx;
        node_wdata = next_label;
      end
      OP_OPEN_B: begin
        node_we    = 1'b1;
        node_waddr = b_idx;
        node_wdata = next_label;
        grp_we     = 1'b1;
        grp_waddr  = GAW'(next_label);
        grp_wdata  = (a_r == b_r) ? COUNT_W'(1) : COUNT_W'(2);
      end
      OP_JOIN: begin
        node_we    = 1'b1;
        node_waddr = join_node;
        node_wdata = join_lbl;
        grp_we     = 1'b1;
        grp_waddr  = GAW'(join_lbl);
        grp_wdata  = join_inc;
      end
      OP_CLR: begin
        node_we    = (32'(idx) < NODES);
        node_waddr = idx[NAW-1:0];
        grp_we     = (32'(idx) < LABELS);
        grp_waddr  = idx[GAW-1:0];
      end
      default: begin
      end
    endcase
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      boot       <= 1'b1;
      out_valid  <= 1'b0;
      next_label <= LABEL_W'(1);
      edge_count <= '0;
    end else begin
      if ((op == OP_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_WR_ZERO: edge_count <= edge_next;
        OP_JOIN:    edge_count <= edge_next;
        OP_OPEN_B: begin
          edge_count <= edge_next;
          next_label <= next_label + LABEL_W'(1);
        end
        OP_CLR_INIT: begin
          next_label <= LABEL_W'(1);
          edge_count <= '0;
        end
        OP_CLR: begin
          if (idx == CLR_LAST) begin
            boot <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (beat) begin
          func_r <= func;
          a_r    <= node_a;
          b_r    <= node_b;
          kept   <= 1'b0;
          joined <= 1'b0;
          opened <= 1'b0;
        end
      end
      OP_RD_B:   la <= node_rdata;
      OP_CAP_LB: lb <= node_rdata;
      OP_RD_CB:  ca <= grp_rdata;
      OP_PICK: begin
        // larger group absorbs; first node's group wins ties
        cb       <= grp_rdata;
        idx      <= '0;
        scan_vld <= 1'b0;
        if (ca >= grp_rdata) begin
          from_lbl <= lb;
          to_lbl   <= la;
        end else begin
          from_lbl <= la;
          to_lbl   <= lb;
        end
      end
      OP_SCAN: begin
        idx_d    <= idx[NAW-1:0];
        idx      <= idx + IW'(1);
        scan_vld <= 1'b1;
      end
      OP_WR_ZERO: begin
        kept   <= 1'b1;
        joined <= 1'b1;
      end
      OP_OPEN_B: begin
        kept   <= 1'b1;
        opened <= 1'b1;
      end
      OP_JOIN: kept <= 1'b1;
      OP_CLR_INIT: begin
        idx    <= '0;
        kept   <= 1'b0;
        joined <= 1'b0;
        opened <= 1'b0;
      end
      OP_CLR: idx <= idx + IW'(1);
      OP_EMIT: begin
        if (out_free) begin
          link_kept       <= kept;
          groups_joined   <= joined;
          group_opened    <= opened;
          tree_edge_total <= edge_count;
        end
      end
      default: begin
      end
    endcase
  end

  stlc_ram #(
    .WIDTH(LABEL_W),
    .DEPTH(NODES)
  ) u_node_label (
    .clk  (clk),
    .we   (node_we),
    .waddr(node_waddr),
    .wdata(node_wdata),
    .raddr(node_raddr),
    .rdata(node_rdata)
  );

  stlc_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(LABELS)
  ) u_group_members (
    .clk  (clk),
    .we   (grp_we),
    .waddr(grp_waddr),
    .wdata(grp_wdata),
    .raddr(grp_raddr),
    .rdata(grp_rdata)
  );

endmodule

// File: design/stlc_checker.sv
module stlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       link_kept,
  input logic       groups_joined,
  input logic       group_opened,
  input logic [7:0] tree_edge_total
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(link_kept)
      && $stable(groups_joined) && $stable(group_opened) && $stable(tree_edge_total))
    else $error("stalled result beat changed");

  // opened or joined implies kept, never both
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!group_opened || link_kept) && (!groups_joined || link_kept)
      && !(group_opened && groups_joined))
    else $error("inconsistent result flags");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_kept |-> tree_edge_total != 8'd0)
    else $error("kept link with zero edge total");

  // clearing pass follows reset
  a_boot: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block ready during clearing pass");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one in work");

endmodule

bind spanning_tree_link_classifier stlc_checker u_stlc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .link_kept      (link_kept),
  .groups_joined  (groups_joined),
  .group_opened   (group_opened),
  .tree_edge_total(tree_edge_total)
);
